FILE: src/refcounted_slot_allocator_defines.svh
// ------------------------------------------------------------------------
// refcounted_slot_allocator_defines.svh
// assertion macros of the slot allocator, included by refcounted_slot_allocator.sv
// ------------------------------------------------------------------------
`ifndef REFCOUNTED_SLOT_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_SLOT_ALLOCATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rsa_pkg.sv
// ------------------------------------------------------------------------
// rsa_pkg
// constants, codes and helpers of the reference-counted slot allocator
// ------------------------------------------------------------------------
package rsa_pkg;

    localparam int unsigned SLOTS_DEF      = 1024;
    localparam int unsigned COUNT_BITS_DEF = 16;

    // bitmap word geometry
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned WORD_SHIFT = 5;

    // fixed port widths
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned SLOT_W   = 10;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CNT_W    = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_ADD     = 2'd1,
        MODE_RELEASE = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_NOT_USED = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // lowest clear bit of a bitmap word
    function automatic logic [WORD_SHIFT-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_SHIFT-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = WORD_SHIFT'(i);
            end
        end
        return idx;
    endfunction

    // bits of the last word that lie beyond the limit read as taken
    function automatic logic [WORD_BITS-1:0] last_pad(input int unsigned limit);
        logic [WORD_BITS-1:0] m;
        int unsigned          rem;
        rem = limit % WORD_BITS;
        m   = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            m[j] = (rem != 0) && (j >= rem);
        end
        return m;
    endfunction

endpackage

FILE: src/rsa_ram.sv
// ------------------------------------------------------------------------
// rsa_ram
// generic single-write, single-read ram with registered read data
// ------------------------------------------------------------------------
module rsa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/refcounted_slot_allocator.sv
// ------------------------------------------------------------------------
// refcounted_slot_allocator
// slot pool with used bitmap, full-word summary and per-slot ref counts
// ------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | to block  | i_in_valid / o_in_ready   | i_mode, i_slot
//  out     | from block| o_out_valid / i_out_ready | o_status, o_slot_out,
//          |           |                           | o_count_after, o_slot_freed
//
//  add / release: count, bitmap and summary read, then write back
//  allocate: group pick and summary word read, bitmap word read, then write back
//  one item at a time; the next item is taken in the cycle after write back
//  after reset a clearing pass writes each of the ceil(SLOTS/32) bitmap words before o_in_ready
//  a waiting result stalls write back; a new item may enter while it waits
// ------------------------------------------------------------------------
`include "refcounted_slot_allocator_defines.svh"

module refcounted_slot_allocator
    import rsa_pkg::*;
#(
    parameter int unsigned SLOTS      = SLOTS_DEF,
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [SLOT_W-1:0]   i_slot,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic [CNT_W-1:0]    o_count_after,
    output logic                o_slot_freed
);

    localparam int unsigned NWORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned NGRP   = (NWORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned SAW    = $clog2(SLOTS);
    localparam int unsigned WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int unsigned GAW    = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam logic [WORD_BITS-1:0]  BM_PAD    = last_pad(SLOTS);
    localparam logic [WORD_BITS-1:0]  L1_PAD    = last_pad(NWORDS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [3:0] {
        S_CLR  = 4'b0001,
        S_IDLE = 4'b0010,
        S_LVL1 = 4'b0100,
        S_WB   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [WAW-1:0]  r_clr;
    logic [NGRP-1:0] r_grp_full, n_grp_full;

    // item context
    logic [MODE_W-1:0]     r_mode;
    logic [SLOT_W-1:0]     r_slot;
    logic [SAW-1:0]        r_cidx;
    logic [WAW-1:0]        r_word;
    logic [GAW-1:0]        r_grp;
    logic [WORD_SHIFT-1:0] r_bit;
    logic [WORD_SHIFT-1:0] r_wbit;
    logic                  r_in_range;
    logic                  r_full;

    // result register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [CNT_W-1:0]    r_out_count;
    logic                r_out_freed;

    // memory ports
    logic                  bm_we, bm_re, l1_we, l1_re, cnt_we, cnt_re;
    logic [WAW-1:0]        bm_waddr, bm_raddr;
    logic [WORD_BITS-1:0]  bm_wdata, bm_rd;
    logic [GAW-1:0]        l1_waddr, l1_raddr;
    logic [WORD_BITS-1:0]  l1_wdata, l1_rd;
    logic [SAW-1:0]        cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;

    // accept side
    logic                  acc, acc_alloc, any_free;
    logic [GAW-1:0]        alloc_grp;
    logic [31:0]           slot_ext;
    logic [WAW-1:0]        ref_word;
    logic [GAW-1:0]        ref_grp;

    // summary and write back
    logic [WORD_SHIFT-1:0] lvl1_b, wb_j;
    logic [31:0]           lvl1_word_ext, alloc_ext, c32;
    logic [WAW-1:0]        lvl1_word;
    logic                  wb_fire, used;
    logic [COUNT_BITS-1:0] c;
    logic [WORD_BITS-1:0]  bm_new, l1_new;
    t_status               wb_status;
    logic [SLOT_W-1:0]     wb_slot;
    logic [CNT_W-1:0]      wb_count;
    logic                  wb_freed;

    rsa_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (bm_we),
        .i_waddr(bm_waddr),
        .i_wdata(bm_wdata),
        .i_re   (bm_re),
        .i_raddr(bm_raddr),
        .o_rdata(bm_rd)
    );

    // one bit per bitmap word: word is full
    rsa_ram #(.WIDTH(WORD_BITS), .DEPTH(NGRP)) u_summary (
        .i_clk  (i_clk),
        .i_we   (l1_we),
        .i_waddr(l1_waddr),
        .i_wdata(l1_wdata),
        .i_re   (l1_re),
        .i_raddr(l1_raddr),
        .o_rdata(l1_rd)
    );

    rsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(SLOTS)) u_counts (
        .i_clk  (i_clk),
        .i_we   (cnt_we),
        .i_waddr(cnt_waddr),
        .i_wdata(cnt_wdata),
        .i_re   (cnt_re),
        .i_raddr(cnt_raddr),
        .o_rdata(cnt_rd)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && (r_state == S_IDLE);
    assign acc_alloc  = (i_mode == MODE_ALLOC);
    assign slot_ext   = 32'(i_slot);
    assign ref_word   = slot_ext[WAW+WORD_SHIFT-1:WORD_SHIFT];
    assign ref_grp    = GAW'(slot_ext >> (2 * WORD_SHIFT));

    // lowest group that still has a free word
    always_comb begin
        alloc_grp = '0;
        any_free  = 1'b0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (!r_grp_full[g]) begin
                alloc_grp = GAW'(g);
                any_free  = 1'b1;
            end
        end
    end

    assign lvl1_b        = first_zero(l1_rd);
    assign lvl1_word_ext = (32'(r_grp) << WORD_SHIFT) | 32'(lvl1_b);
    assign lvl1_word     = lvl1_word_ext[WAW-1:0];

    assign wb_j      = first_zero(bm_rd);
    assign alloc_ext = (32'(r_word) << WORD_SHIFT) | 32'(wb_j);

    // the count of a free slot reads as zero through the used mask, so the count ram needs no clearing
    assign used = r_in_range && bm_rd[r_bit];
    assign c    = used ? cnt_rd : '0;
    assign c32  = 32'(c);

    assign wb_fire = (r_state == S_WB) && (!r_out_valid || i_out_ready);

    // read side
    always_comb begin
        bm_re     = (acc && !acc_alloc) || (r_state == S_LVL1);
        bm_raddr  = (r_state == S_LVL1) ? lvl1_word : ref_word;
        l1_re     = acc;
        l1_raddr  = acc_alloc ? alloc_grp : ref_grp;
        cnt_re    = acc && !acc_alloc;
        cnt_raddr = slot_ext[SAW-1:0];
    end

    // write back and clearing pass
    always_comb begin
        bm_we      = 1'b0;
        bm_waddr   = r_word;
        bm_wdata   = bm_rd;
        l1_we      = 1'b0;
        l1_waddr   = r_grp;
        l1_wdata   = l1_rd;
        cnt_we     = 1'b0;
        cnt_waddr  = r_cidx;
        cnt_wdata  = c;
        n_grp_full = r_grp_full;
        bm_new     = '0;
        l1_new     = '0;
        wb_status  = ST_NOT_USED;
        wb_slot    = r_slot;
        wb_count   = c32[CNT_W-1:0];
        wb_freed   = 1'b0;

        if (r_state == S_CLR) begin
            bm_we    = 1'b1;
            bm_waddr = r_clr;
            bm_wdata = (r_clr == WAW'(NWORDS - 1)) ? BM_PAD : '0;
            l1_we    = (32'(r_clr) < NGRP);
            l1_waddr = GAW'(r_clr);
            l1_wdata = (32'(r_clr) == NGRP - 1) ? L1_PAD : '0;
        end else if (r_mode == MODE_ALLOC) begin
            if (r_full) begin
                wb_status = ST_NO_FREE;
                wb_slot   = '0;
                wb_count  = '0;
            end else begin
                bm_new    = bm_rd | (WORD_BITS'(1) << wb_j);
                l1_new    = l1_rd | (WORD_BITS'(1) << r_wbit);
                bm_we     = wb_fire;
                bm_wdata  = bm_new;
                cnt_we    = wb_fire;
                cnt_waddr = alloc_ext[SAW-1:0];
                cnt_wdata = COUNT_BITS'(1);
                // word just filled: mark it in the summary
                if (&bm_new) begin
                    l1_we    = wb_fire;
                    l1_wdata = l1_new;
                    if (&l1_new && wb_fire) begin
                        n_grp_full[r_grp] = 1'b1;
                    end
                end
                wb_status = ST_OK;
                wb_slot   = alloc_ext[SLOT_W-1:0];
                wb_count  = CNT_W'(1);
            end
        end else if (used) begin
            case (r_mode)
                MODE_ADD: begin
                    if (c == COUNT_MAX) begin
                        wb_status = ST_OVERFLOW;
                    end else begin
                        cnt_we    = wb_fire;
                        cnt_wdata = c + COUNT_BITS'(1);
                        wb_status = ST_OK;
                        wb_count  = CNT_W'(32'(c) + 32'd1);
                    end
                end
                MODE_RELEASE: begin
                    wb_status = ST_OK;
                    if (c <= COUNT_BITS'(1)) begin
                        cnt_we    = wb_fire;
                        cnt_wdata = '0;
                        bm_we     = wb_fire;
                        bm_wdata  = bm_rd & ~(WORD_BITS'(1) << r_bit);
                        l1_we     = wb_fire;
                        l1_wdata  = l1_rd & ~(WORD_BITS'(1) << r_wbit);
                        if (wb_fire) begin
                            n_grp_full[r_grp] = 1'b0;
                        end
                        wb_count  = '0;
                        wb_freed  = 1'b1;
                    end else begin
                        cnt_we    = wb_fire;
                        cnt_wdata = c - COUNT_BITS'(1);
                        wb_count  = CNT_W'(32'(c) - 32'd1);
                    end
                end
                default: begin
                    wb_status = ST_NOT_USED;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == WAW'(NWORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_state = (acc_alloc && any_free) ? S_LVL1 : S_WB;
                end
            end
            S_LVL1: begin
                n_state = S_WB;
            end
            S_WB: begin
                if (wb_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_grp_full  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_grp_full <= n_grp_full;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + WAW'(1);
            end
            if (wb_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mode     <= i_mode;
            r_slot     <= i_slot;
            r_cidx     <= slot_ext[SAW-1:0];
            r_in_range <= (slot_ext < SLOTS);
            r_full     <= !any_free;
            r_grp      <= acc_alloc ? alloc_grp : ref_grp;
            r_word     <= ref_word;
            r_bit      <= slot_ext[WORD_SHIFT-1:0];
            r_wbit     <= slot_ext[2*WORD_SHIFT-1:WORD_SHIFT];
        end else if (r_state == S_LVL1) begin
            r_word <= lvl1_word;
            r_wbit <= lvl1_b;
        end
        if (wb_fire) begin
            r_out_status <= wb_status;
            r_out_slot   <= wb_slot;
            r_out_count  <= wb_count;
            r_out_freed  <= wb_freed;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot_out    = r_out_slot;
    assign o_count_after = r_out_count;
    assign o_slot_freed  = r_out_freed;

    `RSA_ASSERT_NOW(a_bm_no_collide, i_clk, i_rst_n, bm_we, !bm_re, "bitmap read and write collide")
    `RSA_ASSERT_NOW(a_clr_summary, i_clk, i_rst_n, r_state == S_CLR, r_grp_full == '0, "group full set during clear")
    `RSA_ASSERT_NOW(a_freed_shape, i_clk, i_rst_n, r_out_valid && r_out_freed, r_out_status == ST_OK && r_out_count == '0, "freed item with bad status or count")
    `RSA_ASSERT_NEXT(a_wb_hold, i_clk, i_rst_n, r_state == S_WB && !wb_fire, r_state == S_WB, "write back left while result blocked")
    `RSA_ASSERT_NEXT(a_alloc_one, i_clk, i_rst_n, wb_fire && r_mode == MODE_ALLOC && !r_full, r_out_count == CNT_W'(1) && r_out_status == ST_OK, "allocate did not return count one")

endmodule
